// ===== rtl/bba_pkg.sv =====
// Shared types and constants for the bitmap block allocator.
// No dependencies; used by the top level, bba_byte_eval and bba_checker.
package bba_pkg;

	localparam int unsigned FIELD_W  = 12;
	localparam int unsigned TOTAL_W  = 13;
	localparam int unsigned DATA_W   = 16;
	localparam int unsigned APB_AW   = 3;

	localparam logic [7:0]         FULL_BYTE   = 8'hFF;
	localparam logic [7:0]         TOP_BIT     = 8'h80;
	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic {
		STATUS_OK   = 1'b0,
		STATUS_FULL = 1'b1
	} status_t;

	typedef enum logic {
		REG_TOTAL_BLOCKS = 1'b0,
		REG_UNUSED       = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       nonfull;
		logic       beyond;
		logic [2:0] pos;
	} eval_t;

	function automatic logic [7:0] init_byte(input logic [31:0] byte_idx,
			input int unsigned reserved);
		logic [7:0]  b;
		logic [31:0] blk;
		b = '0;
		for (int k = 0; k < 8; k++) begin
			blk = {byte_idx[28:0], 3'b000} + 32'(k);
			b[7-k] = (blk < reserved);
		end
		return b;
	endfunction

endpackage

// ===== rtl/bitmap_block_allocator.sv =====
// Top level of the bitmap block allocator: sequencer, config register, output word.
// Depends on bba_pkg, bba_bitmap_ram and bba_byte_eval.
//
// After reset the block writes the initial bitmap, one byte per cycle over
// all (MAX_BLOCKS+7)/8 bytes, and accepts no word until that pass ends;
// configuration writes are taken throughout. A free reads the bitmap byte of
// its block and then writes it back with that bit cleared; a block index at or
// beyond MAX_BLOCKS skips both and gives an OK result. An allocate examines N
// bytes: each byte costs one RAM read and one pass through the byte evaluator. The
// scan starts at the lowest byte that may hold a free block, so N is at most 2 for
// a bitmap filled from the bottom and at most (MAX_BLOCKS+7)/8. A new word is
// accepted once the result has moved into the output register.
module bitmap_block_allocator #(
	parameter int unsigned MAX_BLOCKS      = 4096,
	parameter int unsigned RESERVED_BLOCKS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [bba_pkg::DATA_W-1:0]   s_tdata,   // block_index[11:0], zero fill
	input  logic                         s_tuser,   // opcode
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [bba_pkg::DATA_W-1:0]   m_tdata,   // allocated_block[11:0], zero fill
	output logic                         m_tuser,   // status
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bba_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int unsigned BYTES = (MAX_BLOCKS + 7) / 8;
	localparam int unsigned AW    = (BYTES > 1) ? $clog2(BYTES) : 1;
	localparam logic [AW-1:0] LAST = AW'(BYTES - 1);

	bba_pkg::state_t state_q, state_d;

	logic [AW-1:0]                 clr_q;
	logic [AW-1:0]                 ptr_q;
	logic [AW-1:0]                 hint_q;
	bba_pkg::opcode_t              op_q;
	logic [bba_pkg::FIELD_W-1:0]   blk_q;
	logic                          res_status_q;
	logic [bba_pkg::FIELD_W-1:0]   res_blk_q;
	logic                          m_tvalid_q;
	logic                          m_tuser_q;
	logic [bba_pkg::FIELD_W-1:0]   m_blk_q;
	logic [bba_pkg::TOTAL_W-1:0]   total_q;

	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [7:0]                    ram_wdata;
	logic [AW-1:0]                 ram_raddr;
	logic [7:0]                    ram_rdata;

	bba_pkg::eval_t                ev;
	logic [AW+2:0]                 ev_idx;
	logic [31:0]                   ev_idx_ext;

	logic                          in_acc;
	logic                          slot_free;
	logic                          cfg_wr;
	logic [31:0]                   in_blk_ext;
	logic                          in_blk_ok;
	logic [31:0]                   blk_ext;
	logic [AW-1:0]                 free_addr;
	logic [7:0]                    free_mask;

	assign in_acc     = s_tvalid && s_tready;
	assign slot_free  = !m_tvalid_q || m_tready;
	assign in_blk_ext = 32'(s_tdata[bba_pkg::FIELD_W-1:0]);
	assign in_blk_ok  = (in_blk_ext < MAX_BLOCKS);
	assign blk_ext    = 32'(blk_q);
	assign free_addr  = blk_ext[AW+2:3];
	assign free_mask  = bba_pkg::TOP_BIT >> blk_q[2:0];
	assign ram_raddr  = (op_q == bba_pkg::OP_FREE) ? free_addr : ptr_q;
	assign ev_idx_ext = 32'(ev_idx);

	bba_bitmap_ram #(
		.DEPTH(BYTES),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bba_byte_eval #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.AW        (AW)
	) u_eval (
		.byte_in     (ram_rdata),
		.ptr         (ptr_q),
		.total_blocks(total_q),
		.ev          (ev),
		.idx         (ev_idx)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bba_pkg::ST_CLEAR: begin
				if (clr_q == LAST) begin
					state_d = bba_pkg::ST_IDLE;
				end
			end
			bba_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (s_tuser == bba_pkg::OP_FREE) begin
						state_d = in_blk_ok ? bba_pkg::ST_FREE_RD : bba_pkg::ST_DONE;
					end else begin
						state_d = bba_pkg::ST_SCAN_RD;
					end
				end
			end
			bba_pkg::ST_FREE_RD:  state_d = bba_pkg::ST_FREE_WR;
			bba_pkg::ST_FREE_WR:  state_d = bba_pkg::ST_DONE;
			bba_pkg::ST_SCAN_RD:  state_d = bba_pkg::ST_SCAN_CHK;
			bba_pkg::ST_SCAN_CHK: begin
				if (ev.nonfull || ptr_q == LAST) begin
					state_d = bba_pkg::ST_DONE;
				end else begin
					state_d = bba_pkg::ST_SCAN_RD;
				end
			end
			bba_pkg::ST_DONE: begin
				if (slot_free) begin
					state_d = bba_pkg::ST_IDLE;
				end
			end
			default: state_d = bba_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = ram_rdata | (bba_pkg::TOP_BIT >> ev.pos);
		s_tready  = 1'b0;
		unique case (state_q)
			bba_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = bba_pkg::init_byte(32'(clr_q), RESERVED_BLOCKS);
			end
			bba_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			bba_pkg::ST_FREE_WR: begin
				ram_we    = 1'b1;
				ram_waddr = free_addr;
				ram_wdata = ram_rdata & ~free_mask;
			end
			bba_pkg::ST_SCAN_CHK: begin
				ram_we = ev.nonfull && !ev.beyond;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bba_pkg::ST_CLEAR;
			clr_q        <= '0;
			ptr_q        <= '0;
			hint_q       <= '0;
			op_q         <= bba_pkg::OP_ALLOC;
			blk_q        <= '0;
			res_status_q <= bba_pkg::STATUS_OK;
			res_blk_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				bba_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				bba_pkg::ST_IDLE: begin
					if (in_acc) begin
						op_q         <= bba_pkg::opcode_t'(s_tuser);
						blk_q        <= s_tdata[bba_pkg::FIELD_W-1:0];
						ptr_q        <= hint_q;
						res_status_q <= bba_pkg::STATUS_OK;
						res_blk_q    <= '0;
					end
				end
				bba_pkg::ST_FREE_WR: begin
					if (free_addr < hint_q) begin
						hint_q <= free_addr;
					end
				end
				bba_pkg::ST_SCAN_CHK: begin
					if (ev.nonfull) begin
						if (ev.beyond) begin
							res_status_q <= bba_pkg::STATUS_FULL;
						end else begin
							res_blk_q <= ev_idx_ext[bba_pkg::FIELD_W-1:0];
							hint_q    <= ptr_q;
						end
					end else if (ptr_q == LAST) begin
						res_status_q <= bba_pkg::STATUS_FULL;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tuser_q  <= bba_pkg::STATUS_OK;
			m_blk_q    <= '0;
		end else if (state_q == bba_pkg::ST_DONE && slot_free) begin
			m_tvalid_q <= 1'b1;
			m_tuser_q  <= res_status_q;
			m_blk_q    <= res_blk_q;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = bba_pkg::DATA_W'(m_blk_q);

	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= bba_pkg::TOTAL_RESET;
		end else if (cfg_wr && paddr[2] == bba_pkg::REG_TOTAL_BLOCKS) begin
			total_q <= pwdata[bba_pkg::TOTAL_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == bba_pkg::REG_TOTAL_BLOCKS) ? 32'(total_q) : '0;

endmodule

// ===== rtl/bba_bitmap_ram.sv =====
// Usage bitmap storage: one write port, one registered read port.
// Depends on nothing; instantiated by the top level.
module bba_bitmap_ram #(
	parameter int unsigned DEPTH = 512,
	parameter int unsigned AW    = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/bba_byte_eval.sv =====
// Scan unit: finds the lowest free block in one bitmap byte and
// checks it against the bounds. Depends on bba_pkg.
module bba_byte_eval #(
	parameter int unsigned MAX_BLOCKS = 4096,
	parameter int unsigned AW         = 9
) (
	input  logic [7:0]                  byte_in,
	input  logic [AW-1:0]               ptr,
	input  logic [bba_pkg::TOTAL_W-1:0] total_blocks,
	output bba_pkg::eval_t              ev,
	output logic [AW+2:0]               idx
);

	logic [2:0]  pos;
	logic [31:0] idx_ext;

	always_comb begin
		pos = '0;
		for (int k = 7; k >= 0; k--) begin
			if (!byte_in[7-k]) begin
				pos = 3'(k);
			end
		end
	end

	assign idx     = {ptr, pos};
	assign idx_ext = 32'(idx);

	assign ev.nonfull = (byte_in != bba_pkg::FULL_BYTE);
	assign ev.pos     = pos;
	assign ev.beyond  = (idx_ext >= 32'(total_blocks)) || (idx_ext >= MAX_BLOCKS);

endmodule

// ===== rtl/bba_checker.sv =====
// Port-level checks for the bitmap block allocator, bound to the top level.
// Depends on bba_pkg and bitmap_block_allocator.
module bba_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [bba_pkg::DATA_W-1:0] m_tdata,
	input logic                       m_tuser
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a word is still in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result word changed");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == bba_pkg::STATUS_FULL |-> m_tdata == '0)
		else $error("full result carries a block index");

	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[bba_pkg::DATA_W-1:bba_pkg::FIELD_W] == '0)
		else $error("result word has bits above the block index");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
